### hw/rtl/mrrc_pkg.sv
// shared types, codes and the crc-16 byte update for the modbus rtu response checker
package mrrc_pkg;

  // input event codes
  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_TIMEOUT  = 2'd1,
    KIND_LINE_ERR = 2'd2,
    KIND_IGNORED  = 2'd3
  } kind_e;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_CRC_ERR   = 2'd1,
    STATUS_NO_RESP   = 2'd2,
    STATUS_UART_ERR  = 2'd3
  } status_e;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // frame byte positions
  localparam logic [3:0] PosDataFirst = 4'd3;
  localparam logic [3:0] PosCrcLow    = 4'd7;
  localparam logic [3:0] PosCrcHigh   = 4'd8;

  // reflected crc-16, one byte, eight shift steps unrolled
  function automatic logic [15:0] crc16_byte(logic [15:0] crc_in, logic [7:0] data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CrcPoly;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

### hw/rtl/modbus_rtu_response_checker.sv
// modbus rtu read-two-registers response checker, one received byte per word
//
// Input channel (in_valid_i / in_ready_o) carries one event per word: a received
// byte, a receive timeout or a line error (kind_i), plus the byte (rx_byte_i).
// Bytes 0..6 of the 9-byte reply feed a reflected CRC-16 (init FFFF, poly A001);
// bytes 3..6 are kept as a big-endian 32-bit word; bytes 7 and 8 are the
// received CRC, low byte first. After byte 8 one result word leaves on the
// output channel (out_valid_o / out_ready_i): status ok with value_bits, or a
// CRC mismatch. A timeout or line error drops the partial frame and gives one
// result (no response / UART error). Kind 3 is ignored. Other bytes give none.
// Throughput: one input word per cycle while in_ready_o is high; the CRC byte update
// is a single unrolled eight-step network between the frame state registers.
// A result is registered from the decode logic into the output register.
// When the receiver stalls, one further result is held in a skid register;
// in_ready_o drops only while that skid register is full.
// Reset clears the frame state (CRC to FFFF, position 0) and the valid bits of both
// result registers; the block accepts words from the first cycle after reset.
module modbus_rtu_response_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] value_bits_o
);

  // frame state
  logic [3:0]  pos_q, pos_d;
  logic [15:0] crc_q, crc_d;
  logic [31:0] word_q, word_d;
  logic [7:0]  crc_lo_q, crc_lo_d;

  // result of the current word
  logic        res_valid;
  logic [1:0]  res_status;
  logic [31:0] res_value;

  // output and skid registers
  logic        out_valid_q, skid_valid_q;
  logic [1:0]  out_status_q, skid_status_q;
  logic [31:0] out_value_q, skid_value_q;

  logic        in_fire;
  logic        out_free;
  logic [15:0] crc_rx;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign crc_rx     = {rx_byte_i, crc_lo_q};

  // frame state update and result decode
  always_comb begin
    pos_d      = pos_q;
    crc_d      = crc_q;
    word_d     = word_q;
    crc_lo_d   = crc_lo_q;
    res_valid  = 1'b0;
    res_status = mrrc_pkg::STATUS_OK;
    res_value  = '0;
    if (in_fire) begin
      unique case (kind_i) inside
        mrrc_pkg::KIND_TIMEOUT, mrrc_pkg::KIND_LINE_ERR: begin
          res_valid  = 1'b1;
          res_status = (kind_i == mrrc_pkg::KIND_TIMEOUT) ? mrrc_pkg::STATUS_NO_RESP
                                                          : mrrc_pkg::STATUS_UART_ERR;
          pos_d      = '0;
          crc_d      = mrrc_pkg::CrcInit;
          word_d     = '0;
          crc_lo_d   = '0;
        end
        mrrc_pkg::KIND_BYTE: begin
          if (pos_q < mrrc_pkg::PosCrcLow) begin
            crc_d = mrrc_pkg::crc16_byte(crc_q, rx_byte_i);
            if (pos_q >= mrrc_pkg::PosDataFirst) begin
              word_d = {word_q[23:0], rx_byte_i};
            end
            pos_d = pos_q + 4'd1;
          end else if (pos_q == mrrc_pkg::PosCrcLow) begin
            crc_lo_d = rx_byte_i;
            pos_d    = mrrc_pkg::PosCrcHigh;
          end else begin
            res_valid = 1'b1;
            if (crc_rx == crc_q) begin
              res_status = mrrc_pkg::STATUS_OK;
              res_value  = word_q;
            end else begin
              res_status = mrrc_pkg::STATUS_CRC_ERR;
            end
            pos_d    = '0;
            crc_d    = mrrc_pkg::CrcInit;
            word_d   = '0;
            crc_lo_d = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      crc_q    <= mrrc_pkg::CrcInit;
      word_q   <= '0;
      crc_lo_q <= '0;
    end else begin
      pos_q    <= pos_d;
      crc_q    <= crc_d;
      word_q   <= word_d;
      crc_lo_q <= crc_lo_d;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_status_q <= skid_status_q;
        out_value_q  <= skid_value_q;
      end else if (res_valid) begin
        out_status_q <= res_status;
        out_value_q  <= res_value;
      end
    end else if (res_valid) begin
      skid_status_q <= res_status;
      skid_value_q  <= res_value;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign value_bits_o = out_value_q;

  // skid holds a word only behind a waiting output word
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full while output register empty");

  // frame position stays within the nine-byte frame
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= mrrc_pkg::PosCrcHigh)
    else $error("byte position out of range");

  // a result always restarts the frame
  a_result_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |=> (pos_q == 4'd0) && (crc_q == mrrc_pkg::CrcInit))
    else $error("frame state not cleared after result");

  // after an accepted timeout the output register holds a valid word on the next cycle
  a_timeout_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && kind_i == mrrc_pkg::KIND_TIMEOUT) |=> out_valid_q)
    else $error("timeout gave no result");

endmodule
